// ===== rtl/core/drip_rate_window_monitor_macros.svh =====
// assertion macros for the drip rate window monitor checker
// expects signals named clk and rst_n in the scope where a macro is used
`ifndef DRIP_RATE_WINDOW_MONITOR_MACROS_SVH
`define DRIP_RATE_WINDOW_MONITOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define DRWM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("drwm check failed");

// next-cycle implication, disabled during reset
`define DRWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("drwm check failed");

`endif

// ===== rtl/core/drwm_pkg.sv =====
// shared types and constants for the drip rate window monitor
// no dependencies
package drwm_pkg;

  localparam int DROPS_W     = 4;
  localparam int ALARM_W     = 2;
  localparam int SPEED_W     = 24;
  localparam int SUM_FIELD_W = 18;
  localparam int TICK_W      = 16;
  localparam int CFG_W       = 18;
  localparam int CFG_IDX_W   = 2;

  localparam logic [TICK_W-1:0]      TICK_MAX      = 16'hFFFF;
  localparam logic [SUM_FIELD_W-1:0] SUM_FIELD_MAX = 18'h3FFFF;
  localparam logic [SPEED_W-1:0]     SPEED_MAX     = 24'hFFFFFF;

  localparam logic [TICK_W-1:0]      PERIOD_TICKS_RST   = 16'd100;
  localparam logic [TICK_W-1:0]      TIMEOUT_TICKS_RST  = 16'd500;
  localparam logic [CFG_W-1:0]       FAST_SUM_LIMIT_RST = 18'd15;
  localparam logic [CFG_W-1:0]       LOW_SUM_LIMIT_RST  = 18'd1;

  typedef enum logic [ALARM_W-1:0] {
    ALERT_NONE = 2'd0,
    ALERT_DONE = 2'd1,
    ALERT_FAST = 2'd2,
    ALERT_LOW  = 2'd3
  } alarm_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_TICKS   = 2'd0,
    REG_TIMEOUT_TICKS  = 2'd1,
    REG_FAST_SUM_LIMIT = 2'd2,
    REG_LOW_SUM_LIMIT  = 2'd3
  } cfg_idx_t;

  // control shared by every slot cell of the window chain
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/drwm_in_if.sv =====
// tick channel: valid/ready handshake carrying drops and working flag
// depends on drwm_pkg
interface drwm_in_if;
  logic                         valid;
  logic                         ready;
  logic [drwm_pkg::DROPS_W-1:0] drops;
  logic                         working;

  modport source(output valid, output drops, output working, input ready);
  modport sink(input valid, input drops, input working, output ready);
endinterface

// ===== rtl/core/drwm_out_if.sv =====
// result channel: valid/ready handshake carrying alarm, speed and window sum
// depends on drwm_pkg
interface drwm_out_if;
  logic                             valid;
  logic                             ready;
  logic [drwm_pkg::ALARM_W-1:0]     alarm;
  logic [drwm_pkg::SPEED_W-1:0]     speed_q8;
  logic [drwm_pkg::SUM_FIELD_W-1:0] window_sum;
  logic                             rate_updated;

  modport source(output valid, output alarm, output speed_q8, output window_sum,
                 output rate_updated, input ready);
  modport sink(input valid, input alarm, input speed_q8, input window_sum,
               input rate_updated, output ready);
endinterface

// ===== rtl/core/drwm_slot_cell.sv =====
// one slot of the per-period count window, shifts toward the oldest end
// depends on drwm_pkg for the cell control struct
module drwm_slot_cell #(
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  drwm_pkg::cell_ctrl_t   ctrl,
  input  logic [COUNT_BITS-1:0]  count_in,
  output logic [COUNT_BITS-1:0]  count_out
);

  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (ctrl.clear) begin
      count_nxt = '0;
    end else if (ctrl.shift) begin
      count_nxt = count_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count_out = count_r;

endmodule

// ===== rtl/core/drwm_speed.sv =====
// held sum to q.8 drops per period: reciprocal multiply with saturation
// depends on drwm_pkg for field widths
module drwm_speed #(
  parameter int WINDOW_SLOTS = 3,
  parameter int COUNT_BITS   = 16
) (
  input  logic [COUNT_BITS+$clog2(WINDOW_SLOTS)-1:0] held_sum,
  output logic [drwm_pkg::SPEED_W-1:0]               speed_q8
);

  localparam int SUM_W = COUNT_BITS + $clog2(WINDOW_SLOTS);
  localparam int LW    = $clog2(WINDOW_SLOTS);
  // unsaturated sums stay below WINDOW_SLOTS * 2^(SPEED_W-8)
  localparam int XB    = drwm_pkg::SPEED_W - 8 + LW;
  localparam int HW    = (SUM_W > XB + 1) ? SUM_W : XB + 1;
  localparam int K     = XB + 8 + LW;
  localparam int MB    = XB + 9;
  localparam int PW    = XB + MB;

  localparam longint unsigned RECIP =
    ((64'd1 << K) + longint'(WINDOW_SLOTS) - 64'd1) / longint'(WINDOW_SLOTS);
  localparam longint unsigned THRESH =
    longint'(WINDOW_SLOTS) << (drwm_pkg::SPEED_W - 8);

  logic [HW-1:0] held_w;
  logic          sat;
  logic [XB-1:0] x;
  logic [MB-1:0] recip_c;
  logic [PW-1:0] prod;

  assign held_w  = HW'(held_sum);
  assign sat     = held_w >= HW'(THRESH);
  assign x       = held_w[XB-1:0];
  assign recip_c = MB'(RECIP);
  // floor(x * 256 / slots) = (x * recip) >> (K - 8)
  assign prod    = PW'(x) * PW'(recip_c);

  assign speed_q8 = sat ? drwm_pkg::SPEED_MAX : prod[K-8 +: drwm_pkg::SPEED_W];

endmodule

// ===== rtl/core/drip_rate_window_monitor.sv =====
// drip rate window monitor top level: tick intake, window cell chain, result stage
// depends on drwm_pkg, drwm_in_if, drwm_out_if, drwm_slot_cell, drwm_speed
//
// usage
// - in_ch takes one item per timer tick: drops seen in the tick and the working flag
// - out_ch returns exactly one result item per tick item: alarm, speed_q8,
//   window_sum and rate_updated
// - cfg_we/cfg_index/cfg_wdata write period_ticks, timeout_ticks, fast_sum_limit and
//   low_sum_limit; write only while no item is in flight
// - an accepted tick item updates the tick state and the middle stage; its result is then registered
// - throughput: one item per cycle while out_ch is not stalled, set by the counter and window update
//   loop; the result register and the middle stage let intake continue while a
//   finished result waits
// - receiver stall: out_ch holds its item, the middle stage fills, then in_ready drops;
//   no item is lost or repeated
// - reset (rst_n low, synchronous): counters, window slots and sums clear, registers
//   return to period 100, timeout 500, fast limit 15, low limit 1; both channels empty
// - window: a chain of WINDOW_SLOTS cells, each holding one period count, shifting at
//   every period close; the count leaving the far end is taken off the running sum
module drip_rate_window_monitor #(
  parameter int WINDOW_SLOTS = 3,
  parameter int COUNT_BITS   = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  drwm_in_if.sink                          in_ch,
  drwm_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [drwm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [drwm_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int SUM_W = COUNT_BITS + $clog2(WINDOW_SLOTS);
  localparam int CW    = (SUM_W > drwm_pkg::CFG_W) ? SUM_W : drwm_pkg::CFG_W;
  localparam int TW    = drwm_pkg::TICK_W;

  // configuration registers
  logic [TW-1:0]                period_ticks_r;
  logic [TW-1:0]                timeout_ticks_r;
  logic [drwm_pkg::CFG_W-1:0]   fast_sum_limit_r;
  logic [drwm_pkg::CFG_W-1:0]   low_sum_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_ticks_r   <= drwm_pkg::PERIOD_TICKS_RST;
      timeout_ticks_r  <= drwm_pkg::TIMEOUT_TICKS_RST;
      fast_sum_limit_r <= drwm_pkg::FAST_SUM_LIMIT_RST;
      low_sum_limit_r  <= drwm_pkg::LOW_SUM_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (drwm_pkg::cfg_idx_t'(cfg_index))
        drwm_pkg::REG_PERIOD_TICKS:   period_ticks_r   <= cfg_wdata[TW-1:0];
        drwm_pkg::REG_TIMEOUT_TICKS:  timeout_ticks_r  <= cfg_wdata[TW-1:0];
        drwm_pkg::REG_FAST_SUM_LIMIT: fast_sum_limit_r <= cfg_wdata;
        drwm_pkg::REG_LOW_SUM_LIMIT:  low_sum_limit_r  <= cfg_wdata;
      endcase
    end
  end

  // handshake across the two stages
  logic s1_valid_r;
  logic out_valid_r;
  logic out_adv;
  logic accept;

  assign out_adv     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || out_adv;
  assign accept      = in_ch.valid && in_ch.ready;

  // tick state
  logic [COUNT_BITS-1:0] drop_accum_r, drop_accum_nxt;
  logic [SUM_W-1:0]      running_sum_r, running_sum_nxt;
  logic [SUM_W-1:0]      held_sum_r, held_sum_nxt;
  logic [TW-1:0]         period_elapsed_r, period_elapsed_nxt;
  logic [TW-1:0]         since_drop_r, since_drop_nxt;

  logic [TW-1:0]         elapsed_inc;
  logic [TW-1:0]         since_inc;
  logic [COUNT_BITS:0]   accum_add;
  logic [COUNT_BITS-1:0] fresh;
  logic                  close;
  logic [COUNT_BITS-1:0] oldest;
  drwm_pkg::cell_ctrl_t  cell_ctrl;

  // elapsed counters saturate and keep running while idle
  assign elapsed_inc = (period_elapsed_r == drwm_pkg::TICK_MAX) ?
                       period_elapsed_r : period_elapsed_r + TW'(1);
  assign since_inc   = (since_drop_r == drwm_pkg::TICK_MAX) ?
                       since_drop_r : since_drop_r + TW'(1);

  // this tick's drops count before the period closes, accumulator saturates
  assign accum_add = {1'b0, drop_accum_r} + (COUNT_BITS+1)'(in_ch.drops);
  assign fresh     = accum_add[COUNT_BITS] ? {COUNT_BITS{1'b1}} : accum_add[COUNT_BITS-1:0];
  assign close     = in_ch.working && (elapsed_inc >= period_ticks_r);

  always_comb begin
    drop_accum_nxt     = drop_accum_r;
    running_sum_nxt    = running_sum_r;
    held_sum_nxt       = held_sum_r;
    period_elapsed_nxt = period_elapsed_r;
    since_drop_nxt     = since_drop_r;
    cell_ctrl          = '0;
    if (accept) begin
      period_elapsed_nxt = close ? '0 : elapsed_inc;
      since_drop_nxt     = (close && (fresh != '0)) ? '0 : since_inc;
      if (!in_ch.working) begin
        // idle tick empties the window, drops of this tick are discarded
        drop_accum_nxt  = '0;
        running_sum_nxt = '0;
        cell_ctrl.clear = 1'b1;
      end else if (close) begin
        drop_accum_nxt  = '0;
        running_sum_nxt = running_sum_r - SUM_W'(oldest) + SUM_W'(fresh);
        held_sum_nxt    = running_sum_r - SUM_W'(oldest) + SUM_W'(fresh);
        cell_ctrl.shift = 1'b1;
      end else begin
        drop_accum_nxt = fresh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_accum_r     <= '0;
      running_sum_r    <= '0;
      held_sum_r       <= '0;
      period_elapsed_r <= '0;
      since_drop_r     <= '0;
    end else begin
      drop_accum_r     <= drop_accum_nxt;
      running_sum_r    <= running_sum_nxt;
      held_sum_r       <= held_sum_nxt;
      period_elapsed_r <= period_elapsed_nxt;
      since_drop_r     <= since_drop_nxt;
    end
  end

  // window cell chain: cell 0 takes the closing count, the last cell is the oldest
  logic [COUNT_BITS-1:0] slot_count [WINDOW_SLOTS];

  for (genvar i = 0; i < WINDOW_SLOTS; i++) begin : g_slot
    logic [COUNT_BITS-1:0] slot_in;
    if (i == 0) begin : g_head
      assign slot_in = fresh;
    end else begin : g_link
      assign slot_in = slot_count[i-1];
    end
    drwm_slot_cell #(
      .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl),
      .count_in (slot_in),
      .count_out(slot_count[i])
    );
  end

  assign oldest = slot_count[WINDOW_SLOTS-1];

  // middle stage: per-item flags, state registers hold the item's values
  logic s1_working_r;
  logic s1_updated_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (out_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_working_r <= in_ch.working;
      s1_updated_r <= close;
    end
  end

  // result stage: alarm priority, speed and saturated window sum
  drwm_pkg::alarm_t            alarm_nxt;
  logic [drwm_pkg::SPEED_W-1:0] speed_nxt;
  logic [CW-1:0]               held_w;
  logic [CW-1:0]               running_w;
  logic [drwm_pkg::SUM_FIELD_W-1:0] window_nxt;

  assign held_w    = CW'(held_sum_r);
  assign running_w = CW'(running_sum_r);
  assign window_nxt = (running_w > CW'(drwm_pkg::SUM_FIELD_MAX)) ?
                      drwm_pkg::SUM_FIELD_MAX : running_w[drwm_pkg::SUM_FIELD_W-1:0];

  always_comb begin
    priority if (!s1_working_r) begin
      alarm_nxt = drwm_pkg::ALERT_NONE;
    end else if (since_drop_r >= timeout_ticks_r) begin
      alarm_nxt = drwm_pkg::ALERT_DONE;
    end else if (held_w > CW'(fast_sum_limit_r)) begin
      alarm_nxt = drwm_pkg::ALERT_FAST;
    end else if ((held_w != '0) && (held_w <= CW'(low_sum_limit_r))) begin
      alarm_nxt = drwm_pkg::ALERT_LOW;
    end else begin
      alarm_nxt = drwm_pkg::ALERT_NONE;
    end
  end

  drwm_speed #(
    .WINDOW_SLOTS(WINDOW_SLOTS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_speed (
    .held_sum(held_sum_r),
    .speed_q8(speed_nxt)
  );

  drwm_pkg::alarm_t                 out_alarm_r;
  logic [drwm_pkg::SPEED_W-1:0]     out_speed_r;
  logic [drwm_pkg::SUM_FIELD_W-1:0] out_window_r;
  logic                             out_updated_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_alarm_r   <= alarm_nxt;
      out_speed_r   <= speed_nxt;
      out_window_r  <= window_nxt;
      out_updated_r <= s1_updated_r && s1_working_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.alarm        = out_alarm_r;
  assign out_ch.speed_q8     = out_speed_r;
  assign out_ch.window_sum   = out_window_r;
  assign out_ch.rate_updated = out_updated_r;

endmodule

// ===== rtl/core/drwm_checker.sv =====
// port-level checks for the drip rate window monitor, bound to the top level
// depends on drwm_pkg and drip_rate_window_monitor_macros.svh
`include "drip_rate_window_monitor_macros.svh"

module drwm_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [drwm_pkg::ALARM_W-1:0]     out_alarm,
  input logic [drwm_pkg::SPEED_W-1:0]     out_speed_q8,
  input logic [drwm_pkg::SUM_FIELD_W-1:0] out_window_sum,
  input logic                             out_rate_updated
);

  localparam int PAYLOAD_W = drwm_pkg::ALARM_W + drwm_pkg::SPEED_W +
                             drwm_pkg::SUM_FIELD_W + 1;

  logic                 stalled;
  logic                 closed;
  logic                 fresh_empty;
  logic                 rate_alarm;
  logic                 speed_zero_ok;
  logic [PAYLOAD_W-1:0] payload;

  assign stalled       = out_valid && !out_ready;
  assign closed        = out_valid && out_rate_updated;
  assign fresh_empty   = closed && (out_window_sum == '0);
  assign rate_alarm    = (out_alarm == drwm_pkg::ALERT_FAST) ||
                         (out_alarm == drwm_pkg::ALERT_LOW);
  assign speed_zero_ok = ((out_speed_q8 == '0) == (out_window_sum == '0));
  assign payload       = {out_alarm, out_speed_q8, out_window_sum, out_rate_updated};

  // stalled result keeps valid and payload
  `DRWM_ASSERT_NEXT(a_out_hold, stalled, out_valid)
  `DRWM_ASSERT_NEXT(a_out_stable, stalled, $stable(payload))
  // at a period close the held sum equals the window sum: empty window, no rate alarms
  `DRWM_ASSERT_NOW(a_empty_no_rate_alarm, fresh_empty, !rate_alarm)
  // at a period close speed is zero exactly when the window is empty
  `DRWM_ASSERT_NOW(a_speed_zero_match, closed, speed_zero_ok)

endmodule

bind drip_rate_window_monitor drwm_checker u_drwm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_alarm       (out_ch.alarm),
  .out_speed_q8    (out_ch.speed_q8),
  .out_window_sum  (out_ch.window_sum),
  .out_rate_updated(out_ch.rate_updated)
);

// ===== sim/drip_rate_window_monitor_test.sv =====
// testbench for the drip rate window monitor: directed and random tick items
// checked item by item against a scoreboard that predicts every result
// depends on drwm_pkg, drwm_in_if, drwm_out_if and drip_rate_window_monitor
`timescale 1ns / 1ps

module drip_rate_window_monitor_test;

  localparam int              SLOTS      = 3;
  localparam int              ACCUM_BITS = 16;
  localparam logic [ACCUM_BITS-1:0] ACCUM_MAX = '1;
  localparam int unsigned     RX_HOLD_CYCLES = 80;

  // one result item as the block should present it
  typedef struct {
    drwm_pkg::alarm_t                 alarm;
    logic [drwm_pkg::SPEED_W-1:0]     speed_q8;
    logic [drwm_pkg::SUM_FIELD_W-1:0] window_sum;
    logic                             rate_updated;
  } tick_result_t;

  // flavors of random tick traffic
  typedef enum {FLOW_QUIET, FLOW_TRICKLE, FLOW_BUSY, FLOW_IDLE, FLOW_NOISE} flow_t;

  // mirrors the block: register copies, window state and the queue of results due
  class drip_scoreboard;
    logic [drwm_pkg::TICK_W-1:0]      period_ticks;
    logic [drwm_pkg::TICK_W-1:0]      timeout_ticks;
    logic [drwm_pkg::CFG_W-1:0]       fast_limit;
    logic [drwm_pkg::CFG_W-1:0]       low_limit;

    logic [ACCUM_BITS-1:0]            drop_accum;
    logic [ACCUM_BITS-1:0]            slot_count [SLOTS];
    logic [drwm_pkg::SUM_FIELD_W-1:0] window_total;
    logic [drwm_pkg::SUM_FIELD_W-1:0] held_total;
    int unsigned                      slot_idx;
    logic [drwm_pkg::TICK_W-1:0]      elapsed;
    logic [drwm_pkg::TICK_W-1:0]      since_drop;

    tick_result_t           results_due [$];

    int unsigned errors;
    int unsigned ticks;
    int unsigned closes;
    int unsigned accum_limit_ticks;
    int unsigned counter_limit_ticks;
    int unsigned alarm_seen [4];

    function new();
      period_ticks  = drwm_pkg::PERIOD_TICKS_RST;
      timeout_ticks = drwm_pkg::TIMEOUT_TICKS_RST;
      fast_limit    = drwm_pkg::FAST_SUM_LIMIT_RST;
      low_limit     = drwm_pkg::LOW_SUM_LIMIT_RST;
      drop_accum    = '0;
      foreach (slot_count[i]) slot_count[i] = '0;
      window_total  = '0;
      held_total    = '0;
      slot_idx      = 0;
      elapsed       = '0;
      since_drop    = '0;
    endfunction

    function void set_reg(drwm_pkg::cfg_idx_t idx, logic [drwm_pkg::CFG_W-1:0] value);
      case (idx)
        drwm_pkg::REG_PERIOD_TICKS:   period_ticks  = value[drwm_pkg::TICK_W-1:0];
        drwm_pkg::REG_TIMEOUT_TICKS:  timeout_ticks = value[drwm_pkg::TICK_W-1:0];
        drwm_pkg::REG_FAST_SUM_LIMIT: fast_limit    = value;
        drwm_pkg::REG_LOW_SUM_LIMIT:  low_limit     = value;
        default: ;
      endcase
    endfunction

    function int waiting();
      return results_due.size();
    endfunction

    // advance the mirror by one accepted tick item and queue its result
    function void note_tick(logic [drwm_pkg::DROPS_W-1:0] drops, logic working);
      tick_result_t r;
      int unsigned  acc;
      int unsigned  total;
      int unsigned  speed;
      ticks++;
      r.alarm        = drwm_pkg::ALERT_NONE;
      r.rate_updated = 1'b0;
      if (elapsed != drwm_pkg::TICK_MAX) elapsed++;
      if (since_drop != drwm_pkg::TICK_MAX) since_drop++;
      if (since_drop == drwm_pkg::TICK_MAX) counter_limit_ticks++;
      if (!working) begin
        drop_accum   = '0;
        window_total = '0;
        foreach (slot_count[i]) slot_count[i] = '0;
      end else begin
        acc = drop_accum;
        acc = acc + drops;
        if (acc >= ACCUM_MAX) begin
          drop_accum = ACCUM_MAX;
          accum_limit_ticks++;
        end else begin
          drop_accum = acc[ACCUM_BITS-1:0];
        end
        if (elapsed >= period_ticks) begin
          if (drop_accum != 0) since_drop = '0;
          total = window_total;
          total = total - slot_count[slot_idx] + drop_accum;
          window_total         = total[drwm_pkg::SUM_FIELD_W-1:0];
          slot_count[slot_idx] = drop_accum;
          drop_accum           = '0;
          slot_idx             = (slot_idx == SLOTS - 1) ? 0 : slot_idx + 1;
          held_total           = window_total;
          elapsed              = '0;
          r.rate_updated       = 1'b1;
          closes++;
        end
        if (since_drop >= timeout_ticks) r.alarm = drwm_pkg::ALERT_DONE;
        else if (held_total > fast_limit) r.alarm = drwm_pkg::ALERT_FAST;
        else if (held_total != 0 && held_total <= low_limit) r.alarm = drwm_pkg::ALERT_LOW;
      end
      alarm_seen[r.alarm]++;
      speed = held_total;
      speed = speed * 256 / SLOTS;
      r.speed_q8   = (speed > drwm_pkg::SPEED_MAX) ? drwm_pkg::SPEED_MAX :
                     speed[drwm_pkg::SPEED_W-1:0];
      r.window_sum = window_total;
      results_due.push_back(r);
    endfunction

    function void check_result(logic [drwm_pkg::ALARM_W-1:0] alarm,
                               logic [drwm_pkg::SPEED_W-1:0] speed_q8,
                               logic [drwm_pkg::SUM_FIELD_W-1:0] window_sum,
                               logic rate_updated);
      tick_result_t want;
      if (results_due.size() == 0) begin
        $error("result item with no tick item pending");
        errors++;
        return;
      end
      want = results_due.pop_front();
      if (alarm !== want.alarm) begin
        $error("alarm: expected %0d, got %0d", want.alarm, alarm);
        errors++;
      end
      if (speed_q8 !== want.speed_q8) begin
        $error("speed_q8: expected %0d, got %0d", want.speed_q8, speed_q8);
        errors++;
      end
      if (window_sum !== want.window_sum) begin
        $error("window_sum: expected %0d, got %0d", want.window_sum, window_sum);
        errors++;
      end
      if (rate_updated !== want.rate_updated) begin
        $error("rate_updated: expected %0d, got %0d", want.rate_updated, rate_updated);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  logic                           cfg_we;
  logic [drwm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [drwm_pkg::CFG_W-1:0]     cfg_wdata;

  drwm_in_if  in_ch ();
  drwm_out_if out_ch ();

  drip_scoreboard sb;

  // idle odds in percent for each side, and a long receiver hold-off on request
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic        rx_hold_on;
  int unsigned rx_hold_cnt;
  int unsigned settings_used;

  drip_rate_window_monitor #(
    .WINDOW_SLOTS(SLOTS),
    .COUNT_BITS  (ACCUM_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // receiver: random stalls, or a counted hold-off so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_hold_cnt  <= 0;
    end else if (rx_hold_on && (rx_hold_cnt < RX_HOLD_CYCLES)) begin
      out_ch.ready <= 1'b0;
      rx_hold_cnt  <= rx_hold_cnt + 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // both handshakes are sampled at the edge, before any driver update lands
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_tick(in_ch.drops, in_ch.working);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.alarm, out_ch.speed_q8, out_ch.window_sum,
                        out_ch.rate_updated);
    end
  end

  // offer one tick item, maybe after some idle cycles, and hold it until taken
  task automatic send_tick(input logic [drwm_pkg::DROPS_W-1:0] drops, input logic working);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.drops   <= drops;
    in_ch.working <= working;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // stop offering and wait until every queued result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.waiting() != 0) @(posedge clk);
    // the extra edges below keep any stray result in view
    repeat (4) @(posedge clk);
  endtask

  // write all four registers back to back, only ever while the block is empty
  task automatic write_regs(input logic [drwm_pkg::CFG_W-1:0] period, timeout, fast, low);
    drwm_pkg::cfg_idx_t         order [4] = '{drwm_pkg::REG_PERIOD_TICKS,
                                              drwm_pkg::REG_TIMEOUT_TICKS,
                                              drwm_pkg::REG_FAST_SUM_LIMIT,
                                              drwm_pkg::REG_LOW_SUM_LIMIT};
    logic [drwm_pkg::CFG_W-1:0] vals  [4];
    vals = '{period, timeout, fast, low};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(order[i], vals[i]);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    flow_t                        flow;
    int unsigned                  burst_left;
    int unsigned                  pick;
    logic [drwm_pkg::DROPS_W-1:0] drops;
    logic                         working;

    sb            = new();
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.drops   = '0;
    in_ch.working = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = drwm_pkg::REG_PERIOD_TICKS;
    cfg_wdata     = '0;
    tx_idle_pct   = 21;
    rx_idle_pct   = 60;
    rx_hold_on    = 1'b0;
    settings_used = 1;
    burst_left    = 0;
    flow          = FLOW_BUSY;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // power-on settings: idle tick, a full tick, an empty tick
    send_tick(4'd0, 1'b0);
    send_tick(4'd15, 1'b1);
    send_tick(4'd0, 1'b1);
    drain_results();

    // data bits above a 16 bit register are dropped, so this is a zero period:
    // every working tick closes, the window climbs into fast, decays into low,
    // then the drop timeout raises complete
    write_regs(18'h30000, 18'd3, 18'd20, 18'd2);
    send_tick(4'd15, 1'b1);
    send_tick(4'd15, 1'b1);
    send_tick(4'd15, 1'b1);
    send_tick(4'd1, 1'b1);
    send_tick(4'd0, 1'b1);
    send_tick(4'd0, 1'b1);
    send_tick(4'd0, 1'b1);
    send_tick(4'd0, 1'b1);
    // idle tick wipes the window but keeps the held rate
    send_tick(4'd9, 1'b0);
    send_tick(4'd1, 1'b1);
    send_tick(4'd0, 1'b1);
    send_tick(4'd0, 1'b1);
    drain_results();

    // zero timeout: every working tick reports complete; longest period
    write_regs(18'h0FFFF, 18'd0, 18'd0, 18'd0);
    send_tick(4'd15, 1'b1);
    send_tick(4'd6, 1'b0);
    send_tick(4'd8, 1'b1);
    drain_results();

    // one tick period with full ticks: the window fills, then settles at the sum of three full ticks
    write_regs(18'd1, 18'h0FFFF, 18'd60000, 18'd0);
    repeat (5) send_tick(4'd15, 1'b1);
    drain_results();

    // random part: six settings over three idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          tx_idle_pct = 21;
          rx_idle_pct = 60;
        end
        1: begin
          tx_idle_pct = 60;
          rx_idle_pct = 21;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (ph == 5)
        write_regs(18'd1, 18'h0FFFF, 18'h3FFFF, 18'h3FFFF);
      else
        write_regs(18'($urandom_range(0, 10)), 18'($urandom_range(0, 40)),
                   18'($urandom_range(0, 80)), 18'($urandom_range(0, 30)));
      // receiver backs off for a long stretch while items keep coming
      if (ph == 4) rx_hold_on = 1'b1;
      repeat (275) begin
        if (burst_left == 0) begin
          pick = $urandom_range(0, 9);
          if (pick < 2) flow = FLOW_QUIET;
          else if (pick < 4) flow = FLOW_TRICKLE;
          else if (pick < 7) flow = FLOW_BUSY;
          else if (pick == 7) flow = FLOW_IDLE;
          else flow = FLOW_NOISE;
          burst_left = (flow == FLOW_IDLE) ? $urandom_range(1, 6) : $urandom_range(4, 40);
        end
        burst_left--;
        working = 1'b1;
        case (flow)
          FLOW_QUIET:   drops = '0;
          FLOW_TRICKLE: drops = ($urandom_range(0, 3) == 0) ? 4'd1 : 4'd0;
          FLOW_BUSY:    drops = 4'($urandom_range(0, 15));
          FLOW_IDLE: begin
            drops   = 4'($urandom_range(0, 15));
            working = 1'b0;
          end
          default: begin
            drops   = 4'($urandom_range(0, 15));
            working = 1'($urandom_range(0, 1));
          end
        endcase
        send_tick(drops, working);
      end
      drain_results();
    end

    $display("covered %0d tick items under %0d register settings, %0d period closes",
             sb.ticks, settings_used, sb.closes);
    $display("alarms none/complete/fast/low %0d/%0d/%0d/%0d, %0d accumulator and %0d counter limit ticks",
             sb.alarm_seen[drwm_pkg::ALERT_NONE], sb.alarm_seen[drwm_pkg::ALERT_DONE],
             sb.alarm_seen[drwm_pkg::ALERT_FAST], sb.alarm_seen[drwm_pkg::ALERT_LOW],
             sb.accum_limit_ticks, sb.counter_limit_ticks);
    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard, several times the slowest expected run
  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== drip_rate_window_monitor.f =====
+incdir+rtl/core
rtl/core/drwm_pkg.sv
rtl/core/drwm_in_if.sv
rtl/core/drwm_out_if.sv
rtl/core/drwm_slot_cell.sv
rtl/core/drwm_speed.sv
rtl/core/drip_rate_window_monitor.sv
rtl/core/drwm_checker.sv
sim/drip_rate_window_monitor_test.sv
